FILE: rtl/trsm_pkg.sv
`default_nettype none

package trsm_pkg;

  localparam int unsigned NumTracks = 4;
  localparam int unsigned AddrW = 4;

  typedef enum logic [1:0] {
    RegDriveGain  = 2'd0,
    RegMaxSpeed   = 2'd1,
    RegSlowFactor = 2'd2,
    RegHoldMs     = 2'd3
  } reg_idx_e;

  localparam logic [14:0] DriveGainRst  = 15'd10000;
  localparam logic [14:0] MaxSpeedRst   = 15'd20000;
  localparam logic [8:0]  SlowFactorRst = 9'd128;
  localparam logic [15:0] HoldMsRst     = 16'd1000;

  localparam logic [8:0] AngleA    = 9'd225;
  localparam logic [8:0] AngleB    = 9'd180;
  localparam logic [8:0] AngleX    = 9'd135;
  localparam logic [8:0] AngleY    = 9'd90;
  localparam logic [8:0] AngleFull = 9'd360;
  localparam logic [8:0] AngleRst  = 9'd180;

  localparam logic [1:0] FlipZero  = 2'b00;
  localparam logic [1:0] FlipPlus  = 2'b01;
  localparam logic [1:0] FlipMinus = 2'b11;

  typedef logic signed [2:0] dir_t;

  localparam dir_t LiftDir [NumTracks] = '{-3'sd1, 3'sd1, 3'sd1, -3'sd1};
  localparam dir_t TiltVec [4][NumTracks] = '{
    '{-3'sd1,  3'sd1, -3'sd1,  3'sd1},
    '{ 3'sd1, -3'sd1,  3'sd1, -3'sd1},
    '{ 3'sd1,  3'sd1, -3'sd1, -3'sd1},
    '{-3'sd1, -3'sd1,  3'sd1,  3'sd1}
  };

  typedef struct packed {
    logic signed [15:0] stick_y;
    logic signed [15:0] stick_x;
    logic [31:0]        time_ms;
    logic [3:0]         face_buttons;
    logic [3:0]         dpad;
    logic [3:0]         shoulder;
    logic [2:0]         misc_buttons;
  } in_item_t;

  typedef struct packed {
    logic               emergency_stop;
    logic               slow_mode;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [7:0]         flipper_cmds;
    logic               use_position;
    logic [8:0]         target_fr;
    logic [8:0]         target_fl;
    logic [8:0]         target_rr;
    logic [8:0]         target_rl;
    logic               level_request;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/trsm_if.sv
`default_nettype none

interface trsm_in_if;
  logic               valid;
  logic               ready;
  trsm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trsm_out_if;
  logic                valid;
  logic                ready;
  trsm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/tracked_robot_simultaneous_mapper.sv
// Gamepad-to-command mapper for a tracked robot with four flippers. One sample is
// taken per transfer and produces exactly one command transfer. The block handles one
// sample at a time: after a sample is taken, its result is computed and then loaded into
// the output register, and input ready returns in the cycle right after that load, so no
// new sample is taken while one is still being computed. The pace is set by the single
// shared multiplier, which makes three passes per sample (slow-mode gain, left mix,
// right mix), each followed by a register, and by a final state that saturates the
// right speed and loads the output register. A finished result may wait
// in the output register while the next sample is already being processed; the block
// stalls only when a second result is ready before the first is taken. Registers sit on
// the APB port at byte addresses 0, 4, 8 and 12 and should be written only while the
// block is idle.
`default_nettype none

module tracked_robot_simultaneous_mapper (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  trsm_in_if.sink                    req_i,
  trsm_out_if.source                 rsp_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [trsm_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StGain  = 3'd1;
  localparam logic [2:0] StLeft  = 3'd2;
  localparam logic [2:0] StRight = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  function automatic logic signed [15:0] sat_speed(input logic signed [34:0] p,
                                                   input logic [14:0] lim);
    logic signed [34:0] adj;
    logic signed [19:0] q;
    logic signed [19:0] l;
    logic signed [19:0] r;
    adj = p + (p[34] ? 35'sd32767 : 35'sd0);
    q = adj[34:15];
    l = $signed({5'b0, lim});
    if (q > l) begin
      r = l;
    end else if (q < -l) begin
      r = -l;
    end else begin
      r = q;
    end
    return r[15:0];
  endfunction

  logic [14:0] drive_gain_q, max_speed_q;
  logic [8:0]  slow_factor_q;
  logic [15:0] hold_ms_q;

  logic [2:0]  state_q, state_d;
  logic        slow_q, slow_d;
  logic        prev_click_q;
  logic [2:0]  held_q, held_d;
  logic [31:0] hold_start_q, hold_start_d;
  logic        pose_valid_q, pose_valid_d;
  logic [8:0]  pose_a_q, pose_a_d;

  logic                      out_valid_q, out_valid_d;
  trsm_pkg::out_item_t       out_q, out_d;
  trsm_pkg::out_item_t       res_q, res_d;
  logic signed [16:0]        mix_l_q, mix_r_q;
  logic [15:0]               gain_q, gain_sel;
  logic signed [15:0]        left_q;
  logic signed [34:0]        prod_q;
  logic signed [17:0]        mul_a;
  logic signed [16:0]        mul_b;

  logic accept, out_free, load_out, cfg_wr;

  logic              click, share;
  logic [3:0]        dpad;
  logic [3:0]        sh;
  logic [3:0]        face;
  trsm_pkg::dir_t    front, rear, lift, tsum;
  logic              tilt_vld;
  logic [1:0]        tilt_idx;
  logic              manual;
  logic              pressed_vld;
  logic [1:0]        pressed_idx;
  logic [8:0]        face_ang;
  logic [31:0]       elapsed;
  logic              pv;
  logic [7:0]        cmds;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign accept   = req_i.valid & req_i.ready;
  assign out_free = ~out_valid_q | rsp_o.ready;
  assign load_out = (state_q == StDone) & out_free;

  assign req_i.ready = (state_q == StIdle);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  always_comb begin
    case (trsm_pkg::reg_idx_e'(paddr[3:2]))
      trsm_pkg::RegDriveGain:  prdata = {17'b0, drive_gain_q};
      trsm_pkg::RegMaxSpeed:   prdata = {17'b0, max_speed_q};
      trsm_pkg::RegSlowFactor: prdata = {23'b0, slow_factor_q};
      trsm_pkg::RegHoldMs:     prdata = {16'b0, hold_ms_q};
      default:                 prdata = '0;
    endcase
  end

  always_comb begin
    click = req_i.data.misc_buttons[0];
    share = req_i.data.misc_buttons[1];
    dpad  = req_i.data.dpad;
    sh    = req_i.data.shoulder;
    face  = req_i.data.face_buttons;

    slow_d = slow_q ^ (click & ~prev_click_q);

    front = trsm_pkg::dir_t'({2'b0, sh[0]}) - trsm_pkg::dir_t'({2'b0, sh[1]});
    rear  = trsm_pkg::dir_t'({2'b0, sh[2]}) - trsm_pkg::dir_t'({2'b0, sh[3]});

    tilt_vld = (dpad != 4'd0) && ((dpad & (dpad - 4'd1)) == 4'd0);
    tilt_idx = {dpad[3] | dpad[2], dpad[3] | dpad[1]};
    manual   = (front != 3'sd0) || (rear != 3'sd0) || tilt_vld;

    for (int i = 0; i < trsm_pkg::NumTracks; i++) begin
      lift = (i < 2) ? front : rear;
      tsum = (trsm_pkg::LiftDir[i] < 3'sd0) ? -lift : lift;
      if (tilt_vld) begin
        tsum = tsum + trsm_pkg::TiltVec[tilt_idx][i];
      end
      if (tsum > 3'sd0) begin
        cmds[2*i +: 2] = trsm_pkg::FlipPlus;
      end else if (tsum < 3'sd0) begin
        cmds[2*i +: 2] = trsm_pkg::FlipMinus;
      end else begin
        cmds[2*i +: 2] = trsm_pkg::FlipZero;
      end
    end

    pressed_vld = |face;
    if (face[0]) begin
      pressed_idx = 2'd0;
    end else if (face[1]) begin
      pressed_idx = 2'd1;
    end else if (face[2]) begin
      pressed_idx = 2'd2;
    end else begin
      pressed_idx = 2'd3;
    end
    case (pressed_idx)
      2'd0:    face_ang = trsm_pkg::AngleA;
      2'd1:    face_ang = trsm_pkg::AngleB;
      2'd2:    face_ang = trsm_pkg::AngleX;
      default: face_ang = trsm_pkg::AngleY;
    endcase

    elapsed = req_i.data.time_ms - hold_start_q;

    held_d       = held_q;
    hold_start_d = hold_start_q;
    pose_a_d     = pose_a_q;
    pv           = pose_valid_q & ~manual;
    if (share) begin
      pv     = 1'b0;
      held_d = 3'd0;
    end else if (!pressed_vld) begin
      held_d = 3'd0;
    end else if (held_q != ({1'b0, pressed_idx} + 3'd1)) begin
      held_d       = {1'b0, pressed_idx} + 3'd1;
      hold_start_d = req_i.data.time_ms;
    end else if (elapsed >= {16'b0, hold_ms_q}) begin
      pv       = 1'b1;
      pose_a_d = face_ang;
    end
    pose_valid_d = pv;

    res_d                = '0;
    res_d.emergency_stop = share;
    res_d.slow_mode      = slow_d;
    if (!share) begin
      res_d.flipper_cmds  = cmds;
      res_d.level_request = req_i.data.misc_buttons[2];
      if (pv && !manual) begin
        res_d.use_position = 1'b1;
        res_d.target_fr    = pose_a_d;
        res_d.target_fl    = trsm_pkg::AngleFull - pose_a_d;
        res_d.target_rr    = trsm_pkg::AngleFull - pose_a_d;
        res_d.target_rl    = pose_a_d;
      end
    end
  end

  always_comb begin
    gain_sel = slow_q ? prod_q[23:8] : {1'b0, drive_gain_q};
    case (state_q)
      StGain: begin
        mul_a = $signed({3'b0, drive_gain_q});
        mul_b = $signed({8'b0, slow_factor_q});
      end
      StLeft: begin
        mul_a = {mix_l_q[16], mix_l_q};
        mul_b = $signed({1'b0, gain_sel});
      end
      default: begin
        mul_a = {mix_r_q[16], mix_r_q};
        mul_b = $signed({1'b0, gain_q});
      end
    endcase
  end

  always_comb begin
    out_d = res_q;
    if (!res_q.emergency_stop) begin
      out_d.left_speed  = left_q;
      out_d.right_speed = sat_speed(prod_q, max_speed_q);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept) state_d = StGain;
      StGain:  state_d = StLeft;
      StLeft:  state_d = StRight;
      StRight: state_d = StDone;
      StDone:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_gain_q  <= trsm_pkg::DriveGainRst;
      max_speed_q   <= trsm_pkg::MaxSpeedRst;
      slow_factor_q <= trsm_pkg::SlowFactorRst;
      hold_ms_q     <= trsm_pkg::HoldMsRst;
      state_q       <= StIdle;
      out_valid_q   <= 1'b0;
      slow_q        <= 1'b0;
      prev_click_q  <= 1'b0;
      held_q        <= 3'd0;
      hold_start_q  <= 32'd0;
      pose_valid_q  <= 1'b0;
      pose_a_q      <= trsm_pkg::AngleRst;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        case (trsm_pkg::reg_idx_e'(paddr[3:2]))
          trsm_pkg::RegDriveGain:  drive_gain_q  <= pwdata[14:0];
          trsm_pkg::RegMaxSpeed:   max_speed_q   <= pwdata[14:0];
          trsm_pkg::RegSlowFactor: slow_factor_q <= pwdata[8:0];
          trsm_pkg::RegHoldMs:     hold_ms_q     <= pwdata[15:0];
          default: ;
        endcase
      end
      if (accept) begin
        slow_q       <= slow_d;
        prev_click_q <= click;
        held_q       <= held_d;
        hold_start_q <= hold_start_d;
        pose_valid_q <= pose_valid_d;
        pose_a_q     <= pose_a_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (accept) begin
      res_q   <= res_d;
      mix_l_q <= 17'(req_i.data.stick_y) - 17'(req_i.data.stick_x);
      mix_r_q <= 17'(req_i.data.stick_y) + 17'(req_i.data.stick_x);
    end
    if (state_q == StLeft) begin
      gain_q <= gain_sel;
    end
    if (state_q == StRight) begin
      left_q <= sat_speed(prod_q, max_speed_q);
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/trsm_checker.sv
`default_nettype none

module trsm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                valid_i,
  input logic                ready_i,
  input trsm_pkg::out_item_t data_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && data_i.emergency_stop |-> data_i.left_speed == 16'sd0 &&
      data_i.right_speed == 16'sd0 && data_i.flipper_cmds == 8'd0 &&
      !data_i.use_position && !data_i.level_request)
    else $error("stop result carries drive output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !data_i.use_position |-> data_i.target_fr == 9'd0 &&
      data_i.target_fl == 9'd0 && data_i.target_rr == 9'd0 && data_i.target_rl == 9'd0)
    else $error("pose angles shown without a valid pose");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && data_i.use_position |-> data_i.target_fr == data_i.target_rl &&
      data_i.target_fl == data_i.target_rr &&
      ({1'b0, data_i.target_fr} + {1'b0, data_i.target_fl}) == 10'd360)
    else $error("pose angles are not mirrored");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> data_i.flipper_cmds[1:0] != 2'b10 && data_i.flipper_cmds[3:2] != 2'b10 &&
      data_i.flipper_cmds[5:4] != 2'b10 && data_i.flipper_cmds[7:6] != 2'b10)
    else $error("flipper command uses an undefined code");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(data_i))
    else $error("result changed while stalled");

endmodule

bind tracked_robot_simultaneous_mapper trsm_checker u_trsm_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .valid_i (rsp_o.valid),
  .ready_i (rsp_o.ready),
  .data_i  (rsp_o.data)
);

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import trsm_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemsPerPhase = 275;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned MaxPrinted = 50;

  localparam int LiftSense [4] = '{-1, 1, 1, -1};
  localparam int TiltPattern [4][4] = '{
    '{-1,  1, -1,  1},
    '{ 1, -1,  1, -1},
    '{ 1,  1, -1, -1},
    '{-1, -1,  1,  1}
  };
  localparam logic [8:0] FaceAngle [4] = '{AngleA, AngleB, AngleX, AngleY};

  typedef struct {
    in_item_t  s;
    bit        typed;
    out_item_t want;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  trsm_in_if  req_if ();
  trsm_out_if rsp_if ();

  tracked_robot_simultaneous_mapper dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Copy of the configuration and of the mapper state.
  logic [14:0] cfg_gain = DriveGainRst;
  logic [14:0] cfg_max  = MaxSpeedRst;
  logic [8:0]  cfg_slow = SlowFactorRst;
  logic [15:0] cfg_hold = HoldMsRst;
  logic        slow_on = 1'b0;
  logic        last_click = 1'b0;
  logic [2:0]  held_idx = 3'd0;
  logic [31:0] held_since = 32'd0;
  logic        pose_latched = 1'b0;
  logic [8:0]  pose_deg [4] = '{AngleRst, AngleRst, AngleRst, AngleRst};

  out_item_t   pending_cmds [$];
  row_t        plan [$];

  int unsigned mismatches = 0;
  int unsigned cmds_seen = 0;
  int unsigned samples_sent = 0;
  int unsigned estops = 0;
  int unsigned pose_cmds = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;
  bit          holdoff_req = 1'b0;
  logic [31:0] clock_ms = 32'd0;
  logic [3:0]  face_now = 4'd0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= MaxPrinted) $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic logic signed [15:0] track_rate(longint mix, longint gain);
    longint v;
    longint lim;
    v = (mix * gain) / 32768;
    lim = longint'(cfg_max);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[15:0];
  endfunction

  function automatic out_item_t command_for(in_item_t s);
    out_item_t r;
    longint    gain;
    int        front;
    int        rear;
    int        tilt;
    int        sum;
    int        pick;
    logic      manual;
    logic [8:0] a;
    r = '0;
    if (s.misc_buttons[0] && !last_click) slow_on = !slow_on;
    last_click = s.misc_buttons[0];
    r.slow_mode = slow_on;
    if (s.misc_buttons[1]) begin
      pose_latched = 1'b0;
      held_idx = 3'd0;
      r.emergency_stop = 1'b1;
      return r;
    end
    gain = longint'(cfg_gain);
    if (slow_on) gain = (longint'(cfg_gain) * longint'(cfg_slow)) >>> 8;
    r.left_speed = track_rate(longint'(s.stick_y) - longint'(s.stick_x), gain);
    r.right_speed = track_rate(longint'(s.stick_y) + longint'(s.stick_x), gain);

    front = int'(s.shoulder[0]) - int'(s.shoulder[1]);
    rear = int'(s.shoulder[2]) - int'(s.shoulder[3]);
    case (s.dpad)
      4'b0001: tilt = 0;
      4'b0010: tilt = 1;
      4'b0100: tilt = 2;
      4'b1000: tilt = 3;
      default: tilt = -1;
    endcase
    manual = (front != 0) || (rear != 0) || (tilt >= 0);
    for (int i = 0; i < 4; i++) begin
      sum = (i < 2 ? front : rear) * LiftSense[i];
      if (tilt >= 0) sum += TiltPattern[tilt][i];
      if (sum > 0) r.flipper_cmds[2*i +: 2] = FlipPlus;
      else if (sum < 0) r.flipper_cmds[2*i +: 2] = FlipMinus;
    end
    if (manual) pose_latched = 1'b0;

    pick = -1;
    for (int i = 3; i >= 0; i--) if (s.face_buttons[i]) pick = i;
    if (pick < 0) begin
      held_idx = 3'd0;
    end else if (held_idx != 3'(pick + 1)) begin
      held_idx = 3'(pick + 1);
      held_since = s.time_ms;
    end else if (s.time_ms - held_since >= 32'(cfg_hold)) begin
      a = FaceAngle[pick];
      pose_latched = 1'b1;
      pose_deg[0] = a;
      pose_deg[1] = AngleFull - a;
      pose_deg[2] = AngleFull - a;
      pose_deg[3] = a;
    end

    if (pose_latched && !manual) begin
      r.use_position = 1'b1;
      r.target_fr = pose_deg[0];
      r.target_fl = pose_deg[1];
      r.target_rr = pose_deg[2];
      r.target_rl = pose_deg[3];
    end
    r.level_request = s.misc_buttons[2];
    return r;
  endfunction

  function automatic in_item_t pad(int y, int x, logic [31:0] t, logic [3:0] face,
                                   logic [3:0] dp, logic [3:0] sh, logic [2:0] misc);
    in_item_t s;
    s.stick_y = 16'(y);
    s.stick_x = 16'(x);
    s.time_ms = t;
    s.face_buttons = face;
    s.dpad = dp;
    s.shoulder = sh;
    s.misc_buttons = misc;
    return s;
  endfunction

  function automatic out_item_t plain(logic estop, logic slow, int ls, int rs,
                                      logic [7:0] cmds, logic lvl);
    out_item_t r;
    r = '0;
    r.emergency_stop = estop;
    r.slow_mode = slow;
    r.left_speed = 16'(ls);
    r.right_speed = 16'(rs);
    r.flipper_cmds = cmds;
    r.level_request = lvl;
    return r;
  endfunction

  function automatic logic [15:0] stick_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t next_sample();
    in_item_t    s;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) clock_ms = $urandom;
    else clock_ms += $urandom_range(0, int'(cfg_hold) / 3 + 5);
    s.time_ms = clock_ms;
    s.stick_y = stick_value();
    s.stick_x = stick_value();
    if ($urandom_range(0, 3) == 0) begin
      roll = $urandom_range(0, 9);
      if (roll < 4) face_now = 4'd0;
      else if (roll < 8) face_now = 4'(1 << $urandom_range(0, 3));
      else face_now = 4'($urandom);
    end
    s.face_buttons = face_now;
    roll = $urandom_range(0, 19);
    if (roll < 15) s.dpad = 4'd0;
    else if (roll < 18) s.dpad = 4'(1 << $urandom_range(0, 3));
    else s.dpad = 4'($urandom);
    s.shoulder = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0;
    s.misc_buttons = {1'($urandom), $urandom_range(0, 24) == 0, $urandom_range(0, 3) == 0};
    return s;
  endfunction

  task automatic offer(input in_item_t s, input bit typed, input out_item_t want);
    int unsigned gap;
    out_item_t   cmd;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        req_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    req_if.valid <= 1'b1;
    req_if.data <= s;
    do @(posedge clk_i); while (!req_if.ready);
    cmd = command_for(s);
    if (typed) cmd = want;
    if (cmd.emergency_stop) estops++;
    if (cmd.use_position) pose_cmds++;
    pending_cmds.push_back(cmd);
    samples_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_access(input reg_idx_e idx, input logic write, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] reg_now(reg_idx_e idx);
    case (idx)
      RegDriveGain:  return 32'(cfg_gain);
      RegMaxSpeed:   return 32'(cfg_max);
      RegSlowFactor: return 32'(cfg_slow);
      default:       return 32'(cfg_hold);
    endcase
  endfunction

  task automatic set_reg(input reg_idx_e idx, input logic [31:0] val);
    logic [31:0] rd;
    apb_access(idx, 1'b1, val, rd);
    case (idx)
      RegDriveGain:  cfg_gain = val[14:0];
      RegMaxSpeed:   cfg_max = val[14:0];
      RegSlowFactor: cfg_slow = val[8:0];
      default:       cfg_hold = val[15:0];
    endcase
    apb_access(idx, 1'b0, 32'd0, rd);
    if (rd !== reg_now(idx))
      report($sformatf("register %s reads %0d, expected %0d", idx.name(), rd, reg_now(idx)));
  endtask

  task automatic configure(input logic [31:0] gain, input logic [31:0] lim,
                           input logic [31:0] slow, input logic [31:0] hold);
    set_reg(RegDriveGain, gain);
    set_reg(RegMaxSpeed, lim);
    set_reg(RegSlowFactor, slow);
    set_reg(RegHoldMs, hold);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report($sformatf("command %0d %s: got %0d, expected %0d", cmds_seen, name, got, want));
  endtask

  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (pending_cmds.size() == 0) begin
        report($sformatf("command %0d arrived with no sample outstanding", cmds_seen));
      end else begin
        want = pending_cmds.pop_front();
        check_field("emergency_stop", got.emergency_stop, want.emergency_stop);
        check_field("slow_mode", got.slow_mode, want.slow_mode);
        check_field("left_speed", got.left_speed, want.left_speed);
        check_field("right_speed", got.right_speed, want.right_speed);
        check_field("flipper_cmds", got.flipper_cmds, want.flipper_cmds);
        check_field("use_position", got.use_position, want.use_position);
        check_field("target_fr", got.target_fr, want.target_fr);
        check_field("target_fl", got.target_fl, want.target_fl);
        check_field("target_rr", got.target_rr, want.target_rr);
        check_field("target_rl", got.target_rl, want.target_rl);
        check_field("level_request", got.level_request, want.level_request);
      end
      cmds_seen++;
    end
  end

  // The receiver changes its stall pattern now and then, and on request holds off
  // for a long stretch so that the block backs up into its input.
  initial begin
    int unsigned hold_left;
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    logic        take;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    tick = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 512);
      end
      mode_left--;
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        case (mode)
          0: take = 1'b1;
          1: take = ($urandom_range(0, 3) != 0);
          2: take = ($urandom_range(0, 3) == 0);
          default: take = (tick % 5 < 2);
        endcase
      end
      rsp_if.ready <= take;
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("testbench: no progress after %0d cycles", cycles);
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    logic [31:0] rd;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    // Directed samples at the reset configuration.
    plan.push_back(row_t'{pad(0, 0, 0, 0, 0, 0, 0), 1'b1, plain(0, 0, 0, 0, 8'h00, 0)});
    plan.push_back(row_t'{pad(32767, 0, 0, 0, 0, 0, 0), 1'b1,
                          plain(0, 0, 9999, 9999, 8'h00, 0)});
    plan.push_back(row_t'{pad(-32768, 0, 0, 0, 0, 0, 0), 1'b1,
                          plain(0, 0, -10000, -10000, 8'h00, 0)});
    plan.push_back(row_t'{pad(32767, -32768, 0, 0, 0, 0, 0), 1'b1,
                          plain(0, 0, 19999, 0, 8'h00, 0)});
    plan.push_back(row_t'{pad(-32768, 32767, 0, 0, 0, 0, 0), 1'b1,
                          plain(0, 0, -19999, 0, 8'h00, 0)});
    plan.push_back(row_t'{pad(32767, 32767, 0, 0, 4'hF, 4'hF, 3'b010), 1'b1,
                          plain(1, 0, 0, 0, 8'h00, 0)});
    plan.push_back(row_t'{pad(0, 0, 0, 0, 0, 0, 3'b100), 1'b1, plain(0, 0, 0, 0, 8'h00, 1)});
    plan.push_back(row_t'{pad(0, 0, 0, 0, 0, 4'b0001, 0), 1'b1, plain(0, 0, 0, 0, 8'h07, 0)});
    plan.push_back(row_t'{pad(100, -100, 0, 0, 0, 4'b0010, 0), 1'b0, '0});
    plan.push_back(row_t'{pad(0, 0, 0, 0, 0, 4'b1100, 0), 1'b0, '0});
    plan.push_back(row_t'{pad(0, 0, 0, 0, 0, 4'b0111, 0), 1'b0, '0});
    plan.push_back(row_t'{pad(0, 0, 0, 0, 4'b0001, 0, 0), 1'b0, '0});
    plan.push_back(row_t'{pad(0, 0, 0, 0, 4'b0010, 4'b0100, 0), 1'b0, '0});
    plan.push_back(row_t'{pad(0, 0, 0, 0, 4'b0100, 4'b1000, 0), 1'b0, '0});
    plan.push_back(row_t'{pad(0, 0, 0, 0, 4'b1000, 0, 0), 1'b0, '0});
    plan.push_back(row_t'{pad(0, 0, 0, 0, 4'b0011, 0, 0), 1'b0, '0});
    plan.push_back(row_t'{pad(20000, 5000, 0, 0, 0, 0, 3'b001), 1'b0, '0});
    plan.push_back(row_t'{pad(20000, 5000, 0, 0, 0, 0, 3'b001), 1'b0, '0});
    plan.push_back(row_t'{pad(-20000, 5000, 0, 0, 0, 0, 3'b000), 1'b0, '0});
    plan.push_back(row_t'{pad(0, 0, 100, 4'b0001, 0, 0, 0), 1'b0, '0});
    plan.push_back(row_t'{pad(0, 0, 1100, 4'b0001, 0, 0, 0), 1'b0, '0});
    plan.push_back(row_t'{pad(0, 0, 1200, 4'b0011, 4'b0001, 0, 0), 1'b0, '0});
    plan.push_back(row_t'{pad(0, 0, 32'hFFFF_FE00, 4'b1000, 0, 0, 0), 1'b0, '0});
    plan.push_back(row_t'{pad(0, 0, 32'h0000_0300, 4'b1000, 0, 0, 0), 1'b0, '0});
    plan.push_back(row_t'{pad(1000, 1000, 32'h0000_0400, 4'b1000, 0, 0, 3'b011), 1'b0, '0});

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < 4; i++) begin
      apb_access(reg_idx_e'(i), 1'b0, 32'd0, rd);
      if (rd !== reg_now(reg_idx_e'(i)))
        report($sformatf("register %0d reads %0d after reset", i, rd));
    end

    foreach (plan[i]) offer(plan[i].s, plan[i].typed, plan[i].want);
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: configure(32767, 32767, 511, 65535);
        1: configure(0, 0, 0, 0);
        2: configure(32767, 1500, 256, 1);
        3: configure(1, 32767, 300, 50);
        default: configure($urandom_range(0, 32767), $urandom_range(0, 32767),
                           $urandom_range(0, 511), $urandom_range(0, 4000));
      endcase
      if (p == 0) clock_ms = 32'hFFFF_0000;
      gaps_on = (p != 2);
      if (p == 2) holdoff_req = 1'b1;
      repeat (ItemsPerPhase) offer(next_sample(), 1'b0, '0);
      drain();
    end

    $display("testbench: %0d samples sent, %0d commands checked, %0d emergency stops,",
             samples_sent, cmds_seen, estops);
    $display("testbench: %0d pose commands, %0d register settings including extremes",
             pose_cmds, NumPhases + 1);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/trsm_pkg.sv
rtl/trsm_if.sv
rtl/tracked_robot_simultaneous_mapper.sv
rtl/trsm_checker.sv
test/testbench.sv
